[sv/pfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pell fundamental solution package
// Shared widths, result codes and the request/response words of the
// serial multiplier and divider.
// ----------------------------------------------------------------------------
package pfs_pkg;

	localparam int RadW  = 32;
	localparam int RootW = 16;
	localparam int QW    = 17;
	localparam int CoordW = 64;
	localparam int MplW  = 32;
	localparam int CntW  = 6;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_FOUND = 2'd1,
		ST_WIDE  = 2'd2
	} status_t;

	typedef struct packed {
		logic              start;
		logic [CoordW-1:0] mcand;
		logic [MplW-1:0]   mplier;
		logic [CntW-1:0]   nbits;
		logic [CoordW-1:0] addend;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [CoordW-1:0] prod;
		logic              ovf;
	} mul_rsp_t;

	typedef struct packed {
		logic            start;
		logic [RadW-1:0] dividend;
		logic [QW-1:0]   divisor;
		logic [CntW-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [RadW-1:0] quot;
		logic [QW-1:0]   rem;
	} div_rsp_t;

endpackage

[sv/pfs_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial multiply-add
// Computes mcand * mplier + addend one multiplier bit per cycle, MSB first,
// and flags a result that does not fit in 64 bits.
// ----------------------------------------------------------------------------
module pfs_mul import pfs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic                       busy_q;
	logic [CntW-1:0]            cnt_q;
	logic [MplW-1:0]            mpl_q;
	logic [CoordW-1:0]          mcand_q;
	logic [CoordW-1:0]          add_q;
	logic [CoordW+MplW-1:0]     acc_q;
	logic [CoordW-1:0]          prod_q;
	logic                       ovf_q;
	logic                       done_q;
	logic [CoordW+MplW:0]       sum;

	assign sum = {1'b0, acc_q} + {{(MplW+1){1'b0}}, add_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mpl_q   <= req.mplier;
			mcand_q <= req.mcand;
			add_q   <= req.addend;
			acc_q   <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				acc_q <= {acc_q[CoordW+MplW-2:0], 1'b0}
					+ (mpl_q[MplW-1] ? {{MplW{1'b0}}, mcand_q} : '0);
				mpl_q <= {mpl_q[MplW-2:0], 1'b0};
			end else begin
				prod_q <= sum[CoordW-1:0];
				ovf_q  <= |sum[CoordW+MplW:CoordW];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;
	assign rsp.ovf  = ovf_q;

endmodule

[sv/pfs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle; the dividend arrives
// left-aligned so that its top bit is always the next one brought down.
// ----------------------------------------------------------------------------
module pfs_div import pfs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                busy_q;
	logic                done_q;
	logic [CntW-1:0]     cnt_q;
	logic [RadW-1:0]     dvd_q;
	logic [RadW-1:0]     quot_q;
	logic [QW-1:0]       rem_q;
	logic [QW-1:0]       dsr_q;
	logic [QW:0]         trial;
	logic [QW:0]         diff;
	logic                ge;

	assign trial = {rem_q, dvd_q[RadW-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= req.dividend;
			dsr_q  <= req.divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[QW-1:0] : trial[QW-1:0];
			quot_q <= {quot_q[RadW-2:0], ge};
			dvd_q  <= {dvd_q[RadW-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

[sv/pell_fundamental_solution.sv]
`timescale 1ns / 1ps
// Order of work: the integer square root, then for each partial quotient of the
// continued fraction two serial divisions and three serial multiplies, then in
// Pell mode the squaring.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset: arst_n clears the sequencer, the handshake flags and mode_q.
// ----------------------------------------------------------------------------
// Pell equation fundamental solution
// Expands sqrt(d) as a continued fraction and builds the convergents until
// the fundamental unit of Z[sqrt d] is reached, with its norm sign.
// ----------------------------------------------------------------------------
module pell_fundamental_solution import pfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [RadW-1:0]   radicand,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [CoordW-1:0] unit_x,
	output logic [CoordW-1:0] unit_y,
	output logic              norm_negative
);

	// The sequencer drives one shared multiplier and one shared divider. Each
	// issue state starts a unit for one cycle and the matching wait state
	// holds until that unit reports done.
	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_SQRT  = 18'h00002,
		S_INIT  = 18'h00004,
		S_DIVA  = 18'h00008,
		S_DIVAW = 18'h00010,
		S_MULP  = 18'h00020,
		S_MULPW = 18'h00040,
		S_MULQ  = 18'h00080,
		S_MULQW = 18'h00100,
		S_MULM  = 18'h00200,
		S_MULMW = 18'h00400,
		S_DIVS  = 18'h00800,
		S_DIVSW = 18'h01000,
		S_FIN   = 18'h02000,
		S_SQX   = 18'h04000,
		S_SQXW  = 18'h08000,
		S_SQY   = 18'h10000,
		S_SQYW  = 18'h20000
	} state_t;

	state_t state_q;
	state_t done_next;

	logic                  mode_q;
	logic [RadW-1:0]       d_q;
	logic [RadW-1:0]       sqd_q;
	logic [RootW-1:0]      a0_q;
	logic [QW-1:0]         sqrem_q;
	logic [3:0]            sqcnt_q;
	logic [RootW-1:0]      m_q;
	logic [QW-1:0]         s_q;
	logic [QW-1:0]         a_q;
	logic [QW-1:0]         r_q;
	logic [CoordW-1:0]     p_q, q_q, pp_q, qq_q, np_q;
	logic                  neg_q;
	logic                  res_pend_q;
	status_t               res_st_q;
	logic [CoordW-1:0]     res_x_q, res_y_q;
	logic                  res_neg_q;

	logic                  out_valid_q;
	status_t               out_st_q;
	logic [CoordW-1:0]     out_x_q, out_y_q;
	logic                  out_neg_q;

	mul_req_t mreq;
	mul_rsp_t mrsp;
	div_req_t dreq;
	div_rsp_t drsp;

	// One digit pair of the radicand per cycle for the integer square root.
	logic [QW+1:0] sq_cur;
	logic [QW:0]   sq_trial;
	logic          sq_ge;
	logic [QW+1:0] sq_diff;
	logic [QW-1:0] a0_plus_m;

	assign sq_cur    = {sqrem_q, sqd_q[RadW-1 -: 2]};
	assign sq_trial  = {a0_q, 2'b01};
	assign sq_ge     = sq_cur >= {1'b0, sq_trial};
	assign sq_diff   = sq_cur - {1'b0, sq_trial};
	assign a0_plus_m = {1'b0, a0_q} + {1'b0, m_q};

	pfs_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	pfs_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Operand selection for the shared units.
	always_comb begin
		mreq = '0;
		dreq = '0;
		unique case (state_q)
			S_DIVA: begin
				dreq.start    = 1'b1;
				dreq.dividend = {a0_plus_m, {(RadW-QW){1'b0}}};
				dreq.divisor  = s_q;
				dreq.nbits    = CntW'(QW);
			end
			S_DIVS: begin
				dreq.start    = 1'b1;
				dreq.dividend = d_q - mrsp.prod[RadW-1:0];
				dreq.divisor  = s_q;
				dreq.nbits    = CntW'(RadW);
			end
			S_MULP: begin
				mreq.start  = 1'b1;
				mreq.mcand  = p_q;
				mreq.mplier = {a_q, {(MplW-QW){1'b0}}};
				mreq.nbits  = CntW'(QW);
				mreq.addend = pp_q;
			end
			S_MULQ: begin
				mreq.start  = 1'b1;
				mreq.mcand  = q_q;
				mreq.mplier = {a_q, {(MplW-QW){1'b0}}};
				mreq.nbits  = CntW'(QW);
				mreq.addend = qq_q;
			end
			S_MULM: begin
				mreq.start  = 1'b1;
				mreq.mcand  = {{(CoordW-RootW){1'b0}}, m_q};
				mreq.mplier = {m_q, {(MplW-RootW){1'b0}}};
				mreq.nbits  = CntW'(RootW);
			end
			S_SQX: begin
				mreq.start  = 1'b1;
				mreq.mcand  = p_q;
				mreq.mplier = p_q[MplW-1:0];
				mreq.nbits  = CntW'(MplW);
			end
			S_SQY: begin
				mreq.start  = 1'b1;
				mreq.mcand  = q_q;
				mreq.mplier = p_q[MplW-1:0];
				mreq.nbits  = CntW'(MplW);
			end
			default: begin
				mreq = '0;
				dreq = '0;
			end
		endcase
	end

	assign done_next = S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= 1'b0;
			res_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			// A finished result moves into the output register as soon as it is free.
			if (res_pend_q && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				res_pend_q  <= 1'b0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqcnt_q == 4'd0) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					if (sqrem_q == '0) begin
						res_pend_q <= 1'b1;
						state_q    <= done_next;
					end else begin
						state_q <= S_DIVA;
					end
				end
				S_DIVA:  state_q <= S_DIVAW;
				S_DIVAW: begin
					if (drsp.done) begin
						state_q <= (s_q == QW'(1)) ? S_FIN : S_MULP;
					end
				end
				S_MULP:  state_q <= S_MULPW;
				S_MULPW: begin
					if (mrsp.done) begin
						if (mrsp.ovf) begin
							res_pend_q <= 1'b1;
							state_q    <= done_next;
						end else begin
							state_q <= S_MULQ;
						end
					end
				end
				S_MULQ:  state_q <= S_MULQW;
				S_MULQW: begin
					if (mrsp.done) begin
						if (mrsp.ovf) begin
							res_pend_q <= 1'b1;
							state_q    <= done_next;
						end else begin
							state_q <= S_MULM;
						end
					end
				end
				S_MULM:  state_q <= S_MULMW;
				S_MULMW: begin
					if (mrsp.done) begin
						state_q <= S_DIVS;
					end
				end
				S_DIVS:  state_q <= S_DIVSW;
				S_DIVSW: begin
					if (drsp.done) begin
						state_q <= S_DIVA;
					end
				end
				S_FIN: begin
					if (mode_q && neg_q && (p_q[CoordW-1:MplW] == '0)) begin
						state_q <= S_SQX;
					end else begin
						res_pend_q <= 1'b1;
						state_q    <= done_next;
					end
				end
				S_SQX:  state_q <= S_SQXW;
				S_SQXW: begin
					if (mrsp.done) begin
						if (mrsp.prod[CoordW-1]) begin
							res_pend_q <= 1'b1;
							state_q    <= done_next;
						end else begin
							state_q <= S_SQY;
						end
					end
				end
				S_SQY:  state_q <= S_SQYW;
				S_SQYW: begin
					if (mrsp.done) begin
						res_pend_q <= 1'b1;
						state_q    <= done_next;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the expansion.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				d_q     <= radicand;
				sqd_q   <= radicand;
				a0_q    <= '0;
				sqrem_q <= '0;
				sqcnt_q <= 4'd15;
			end
			S_SQRT: begin
				sqd_q   <= {sqd_q[RadW-3:0], 2'b00};
				sqcnt_q <= sqcnt_q - 1'b1;
				a0_q    <= {a0_q[RootW-2:0], sq_ge};
				sqrem_q <= sq_ge ? sq_diff[QW-1:0] : sq_cur[QW-1:0];
			end
			S_INIT: begin
				// The root's remainder d - a0^2 is the first denominator.
				m_q   <= a0_q;
				s_q   <= sqrem_q;
				p_q   <= {{(CoordW-RootW){1'b0}}, a0_q};
				q_q   <= CoordW'(1);
				pp_q  <= CoordW'(1);
				qq_q  <= '0;
				neg_q <= 1'b0;
				res_st_q  <= ST_NONE;
				res_x_q   <= '0;
				res_y_q   <= '0;
				res_neg_q <= 1'b0;
			end
			S_DIVAW: begin
				if (drsp.done) begin
					a_q   <= drsp.quot[QW-1:0];
					r_q   <= drsp.rem;
					neg_q <= ~neg_q;
				end
			end
			S_MULPW: begin
				if (mrsp.done) begin
					np_q     <= mrsp.prod;
					res_st_q <= ST_WIDE;
				end
			end
			S_MULQW: begin
				if (mrsp.done) begin
					pp_q <= p_q;
					p_q  <= np_q;
					qq_q <= q_q;
					q_q  <= mrsp.prod;
					// m' = s*a - m = (a0 + m - r) - m
					m_q  <= a0_q - r_q[RootW-1:0];
				end
			end
			S_DIVSW: begin
				if (drsp.done) begin
					s_q <= drsp.quot[QW-1:0];
				end
			end
			S_FIN: begin
				if (mode_q && neg_q) begin
					res_st_q <= ST_WIDE;
				end else begin
					res_st_q  <= ST_FOUND;
					res_x_q   <= p_q;
					res_y_q   <= q_q;
					res_neg_q <= neg_q & ~mode_q;
				end
			end
			S_SQXW: begin
				if (mrsp.done) begin
					np_q <= mrsp.prod;
				end
			end
			S_SQYW: begin
				if (mrsp.done && !mrsp.prod[CoordW-1]) begin
					res_st_q <= ST_FOUND;
					res_x_q  <= {np_q[CoordW-2:0], 1'b1};
					res_y_q  <= {mrsp.prod[CoordW-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
		if (res_pend_q && (!out_valid_q || out_ready)) begin
			out_st_q  <= res_st_q;
			out_x_q   <= res_x_q;
			out_y_q   <= res_y_q;
			out_neg_q <= res_neg_q;
		end
	end

	// A word is taken only when the sequencer is idle and no result waits
	// behind the output register.
	assign in_ready      = (state_q == S_IDLE) && !res_pend_q;
	assign out_valid     = out_valid_q;
	assign status        = out_st_q;
	assign unit_x        = out_x_q;
	assign unit_y        = out_y_q;
	assign norm_negative = out_neg_q;

endmodule

[sv/pfs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pell fundamental solution checker
// Port-level properties of the result words, bound to the top level.
// ----------------------------------------------------------------------------
module pfs_props import pfs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic [CoordW-1:0] unit_x,
	input logic [CoordW-1:0] unit_y,
	input logic              norm_negative
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_NONE || status == ST_FOUND || status == ST_WIDE))
		else $error("invalid status code");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_FOUND) |-> (unit_x == '0 && unit_y == '0 && !norm_negative))
		else $error("fields set without a unit");

	// For d = 2 the unit 1 + sqrt(2) has x equal to y.
	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FOUND) |-> (unit_y != '0 && unit_x >= unit_y))
		else $error("found unit is not positive");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(unit_x) && $stable(status)))
		else $error("result word dropped or changed while stalled");

endmodule

bind pell_fundamental_solution pfs_props u_pfs_props (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status(status),
	.unit_x(unit_x),
	.unit_y(unit_y),
	.norm_negative(norm_negative)
);
